// ===== hdl/swfc_pkg.sv =====
package swfc_pkg;

  localparam logic [63:0] START_PATTERN = 64'h37a4c295_37a4c295;
  localparam logic [63:0] END_PATTERN   = 64'h592c4a0d_592c4a0d;

  // end-pattern bytes that land in the store before the match is seen
  localparam int unsigned PATTERN_BYTES = 7;
  localparam int unsigned HEADER_BYTES  = 4;
  localparam int unsigned CHECK_BYTES   = 2;

  localparam logic [9:0] MAX_LENGTH_RESET = 10'd1018;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CHECKSUM  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd2;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_WALK,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/sync_word_frame_checker_core.sv =====
// Push item: one push per cycle while idle; a closing push also waits for the output register.
// Read item: the byte is registered in mem_q_r (one memory read), then loaded into the output register.
// Frame close: the single read port walks bytes 0 to length+5, one per cycle, then the
//   verdict goes to the output register (with no walk for a short header, and the walk
//   stops after the header on a header error); input waits meanwhile.
// Synchronous active-low reset clears window, frame state, count and max_length (1018);
//   frame store contents are not cleared.
module sync_word_frame_checker_core #(
  parameter int STORE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_rx_byte,
  input  logic [9:0]  in_read_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_frame_done,
  output logic [15:0] out_frame_command,
  output logic [15:0] out_frame_length,
  output logic [1:0]  out_frame_status,
  output logic [7:0]  out_read_data,
  input  logic        cfg_write_en,
  input  logic [9:0]  cfg_write_data
);
  import swfc_pkg::*;

  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int PW = ((CW > 16) ? CW : 16) + 1;

  state_t          state_r, state_nxt;
  logic [63:0]     win_r, win_nxt;
  logic            in_frame_r, in_frame_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [9:0]      max_length_r;

  logic [PW-1:0]   pos_r, pos_nxt;
  logic [PW-1:0]   q_pos_r;
  logic            q_vld_r, q_vld_nxt;
  logic [15:0]     sum_r, sum_nxt;
  logic [15:0]     cmd_r, cmd_nxt;
  logic [15:0]     len_r, len_nxt;
  logic [7:0]      chk_lo_r, chk_lo_nxt;
  logic [1:0]      status_r, status_nxt;
  logic            rd_ok_r, rd_ok_nxt;

  logic [7:0]      mem [STORE_DEPTH];
  logic [7:0]      mem_q_r;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [AW-1:0]   mem_ra;

  logic            out_valid_r, out_valid_nxt;
  logic            out_done_r;
  logic [15:0]     out_cmd_r, out_len_r;
  logic [1:0]      out_status_r;
  logic [7:0]      out_data_r;
  logic            out_load;
  logic            ld_done;
  logic [15:0]     ld_cmd, ld_len;
  logic [1:0]      ld_status;
  logic [7:0]      ld_data;

  logic            accept;
  logic            out_busy;
  logic [63:0]     win_shift;
  logic            start_hit, end_hit, close_hit;
  logic [PW-1:0]   idx_ext;
  logic [CW-1:0]   count_inc, count_drop;
  logic [15:0]     len_hdr;
  logic [PW-1:0]   len_plus4;
  logic            walk_done;

  assign win_shift = {win_r[55:0], in_rx_byte};
  assign start_hit = (win_shift == START_PATTERN);
  assign end_hit   = (win_shift == END_PATTERN);
  assign close_hit = (in_operation == OP_PUSH) && end_hit && in_frame_r;
  assign out_busy  = out_valid_r && !out_ready;
  // a push that produces no result may go ahead while the output register is stalled
  assign in_ready  = (state_r == ST_IDLE) &&
                     (!out_busy || ((in_operation == OP_PUSH) && !close_hit));
  assign accept    = in_valid && in_ready;

  assign idx_ext    = PW'(in_read_index);
  assign count_inc  = count_r + CW'(1);
  assign count_drop = (count_r < CW'(PATTERN_BYTES)) ? CW'(0) : count_r - CW'(PATTERN_BYTES);
  assign len_hdr    = {mem_q_r, len_r[7:0]};
  assign len_plus4  = PW'(len_r) + PW'(HEADER_BYTES);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_operation == OP_READ) begin
            state_nxt = ST_READ;
          end else if (close_hit) begin
            state_nxt = (count_drop < CW'(HEADER_BYTES)) ? ST_EMIT : ST_WALK;
          end
        end
      end
      ST_READ: state_nxt = ST_IDLE;
      ST_WALK: begin
        if (walk_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    win_nxt      = win_r;
    in_frame_nxt = in_frame_r;
    count_nxt    = count_r;
    pos_nxt      = pos_r;
    q_vld_nxt    = 1'b0;
    sum_nxt      = sum_r;
    cmd_nxt      = cmd_r;
    len_nxt      = len_r;
    chk_lo_nxt   = chk_lo_r;
    status_nxt   = status_r;
    rd_ok_nxt    = rd_ok_r;
    mem_we       = 1'b0;
    mem_wa       = count_r[AW-1:0];
    mem_ra       = pos_r[AW-1:0];
    walk_done    = 1'b0;
    out_load     = 1'b0;
    ld_done      = 1'b0;
    ld_cmd       = '0;
    ld_len       = '0;
    ld_status    = STATUS_OK;
    ld_data      = '0;

    unique case (state_r)
      ST_IDLE: begin
        mem_ra = idx_ext[AW-1:0];
        if (accept) begin
          if (in_operation == OP_READ) begin
            rd_ok_nxt = (idx_ext < PW'(count_r));
          end else begin
            win_nxt = win_shift;
            if (start_hit) begin
              in_frame_nxt = 1'b1;
              count_nxt    = '0;
            end else if (end_hit) begin
              if (in_frame_r) begin
                count_nxt    = count_drop;
                in_frame_nxt = 1'b0;
                pos_nxt      = '0;
                sum_nxt      = '0;
                cmd_nxt      = '0;
                len_nxt      = '0;
                status_nxt   = STATUS_TOO_SHORT;
              end
            end else if (in_frame_r) begin
              if (count_r < CW'(STORE_DEPTH)) begin
                mem_we    = 1'b1;
                count_nxt = count_inc;
                if (count_inc == CW'(STORE_DEPTH)) begin
                  in_frame_nxt = 1'b0;
                end
              end
            end
          end
        end
      end
      ST_READ: begin
        out_load = 1'b1;
        ld_data  = rd_ok_r ? mem_q_r : 8'd0;
      end
      ST_WALK: begin
        // reads are issued ahead; mem_q_r holds the data for q_pos_r, both registered from pos_r
        pos_nxt = pos_r + PW'(1);
        if (q_vld_r) begin
          if (q_pos_r < PW'(HEADER_BYTES)) begin
            sum_nxt = sum_r + 16'(mem_q_r);
            case (q_pos_r[1:0])
              2'd0: cmd_nxt[7:0]  = mem_q_r;
              2'd1: cmd_nxt[15:8] = mem_q_r;
              2'd2: len_nxt[7:0]  = mem_q_r;
              default: begin
                len_nxt = len_hdr;
                if (len_hdr > 16'(max_length_r)) begin
                  status_nxt = STATUS_TOO_LONG;
                  walk_done  = 1'b1;
                end else if (PW'(count_r) <
                             PW'(len_hdr) + PW'(HEADER_BYTES + CHECK_BYTES)) begin
                  status_nxt = STATUS_TOO_SHORT;
                  walk_done  = 1'b1;
                end
              end
            endcase
          end else if (q_pos_r < len_plus4) begin
            sum_nxt = sum_r + 16'(mem_q_r);
          end else if (q_pos_r == len_plus4) begin
            chk_lo_nxt = mem_q_r;
          end else begin
            status_nxt = (sum_r == {mem_q_r, chk_lo_r}) ? STATUS_OK : STATUS_CHECKSUM;
            walk_done  = 1'b1;
          end
        end
        q_vld_nxt = !walk_done;
      end
      ST_EMIT: begin
        out_load  = 1'b1;
        ld_done   = 1'b1;
        ld_cmd    = cmd_r;
        ld_len    = len_r;
        ld_status = status_r;
      end
      default: begin
      end
    endcase

    out_valid_nxt = out_busy || out_load;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      win_r        <= '0;
      in_frame_r   <= 1'b0;
      count_r      <= '0;
      max_length_r <= MAX_LENGTH_RESET;
      q_vld_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_r       <= win_nxt;
      in_frame_r  <= in_frame_nxt;
      count_r     <= count_nxt;
      q_vld_r     <= q_vld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        max_length_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    q_pos_r  <= pos_r;
    sum_r    <= sum_nxt;
    cmd_r    <= cmd_nxt;
    len_r    <= len_nxt;
    chk_lo_r <= chk_lo_nxt;
    status_r <= status_nxt;
    rd_ok_r  <= rd_ok_nxt;
    if (out_load) begin
      out_done_r   <= ld_done;
      out_cmd_r    <= ld_cmd;
      out_len_r    <= ld_len;
      out_status_r <= ld_status;
      out_data_r   <= ld_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= in_rx_byte;
    end
    mem_q_r <= mem[mem_ra];
  end

  assign out_valid         = out_valid_r;
  assign out_frame_done    = out_done_r;
  assign out_frame_command = out_cmd_r;
  assign out_frame_length  = out_len_r;
  assign out_frame_status  = out_status_r;
  assign out_read_data     = out_data_r;

endmodule

// ===== hdl/swfc_checker.sv =====
module swfc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_operation,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_frame_done,
  input logic [15:0] out_frame_command,
  input logic [15:0] out_frame_length,
  input logic [1:0]  out_frame_status,
  input logic [7:0]  out_read_data
);
  import swfc_pkg::*;

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable({out_frame_done, out_frame_command,
      out_frame_length, out_frame_status, out_read_data}))
    else $error("result item changed while stalled");

  // read data passes through mem_q_r and the output register after the read item is taken
  a_read_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_operation == OP_READ) |=> ##1 out_valid && !out_frame_done)
    else $error("read item result missing");

  a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |-> out_frame_command == 16'd0 &&
      out_frame_length == 16'd0 && out_frame_status == STATUS_OK)
    else $error("read result carries frame fields");

  a_verdict_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_read_data == 8'd0)
    else $error("verdict carries read data");

endmodule

bind sync_word_frame_checker_core swfc_checker u_swfc_checker (.*);

// ===== verif/sync_word_frame_checker_core_test.sv =====
`timescale 1ns / 1ps

module sync_word_frame_checker_core_test;
  import swfc_pkg::*;

  localparam int STORE_DEPTH = 1024;

  typedef struct packed {
    logic        done;
    logic [15:0] cmd;
    logic [15:0] len;
    logic [1:0]  status;
    logic [7:0]  data;
  } frame_result_t;

  // Deframer predictor plus the queue of results it still owes.
  class frame_checker_model;
    logic [63:0]   window;
    bit            in_frame;
    int unsigned   byte_count;
    logic [7:0]    store [STORE_DEPTH];
    logic [9:0]    max_length;
    frame_result_t expected_q[$];
    int unsigned   mismatches;

    function void reset_state();
      window = '0;
      in_frame = 1'b0;
      byte_count = 0;
      max_length = MAX_LENGTH_RESET;
      expected_q.delete();
      mismatches = 0;
    endfunction

    function logic [7:0] stored_at(int unsigned pos);
      if (pos < byte_count && pos < STORE_DEPTH) return store[pos];
      return 8'h00;
    endfunction

    function frame_result_t close_frame();
      frame_result_t r;
      int unsigned   drop, len, i;
      logic [15:0]   byte_sum, chk;
      r = '0;
      r.done = 1'b1;
      drop = (byte_count < PATTERN_BYTES) ? byte_count : PATTERN_BYTES;
      // end-pattern bytes already landed in the store
      for (i = byte_count - drop; i < byte_count; i++) begin
        if (i < STORE_DEPTH) store[i] = 8'h00;
      end
      byte_count -= drop;
      in_frame = 1'b0;
      if (byte_count < HEADER_BYTES) begin
        r.status = STATUS_TOO_SHORT;
        return r;
      end
      r.cmd = {stored_at(1), stored_at(0)};
      r.len = {stored_at(3), stored_at(2)};
      len = r.len;
      if (len > max_length) begin
        r.status = STATUS_TOO_LONG;
      end else if (byte_count < len + HEADER_BYTES + CHECK_BYTES) begin
        r.status = STATUS_TOO_SHORT;
      end else begin
        byte_sum = '0;
        for (i = 0; i < len + HEADER_BYTES; i++) byte_sum += stored_at(i);
        chk = {stored_at(len + HEADER_BYTES + 1), stored_at(len + HEADER_BYTES)};
        r.status = (byte_sum == chk) ? STATUS_OK : STATUS_CHECKSUM;
      end
      return r;
    endfunction

    function void take_item(logic op, logic [7:0] b, logic [9:0] idx);
      frame_result_t r;
      r = '0;
      if (op == OP_READ) begin
        r.data = stored_at(idx);
        expected_q.push_back(r);
        return;
      end
      window = {window[55:0], b};
      if (window == START_PATTERN) begin
        in_frame = 1'b1;
        byte_count = 0;
      end else if (window == END_PATTERN) begin
        if (in_frame) expected_q.push_back(close_frame());
      end else if (in_frame) begin
        if (byte_count < STORE_DEPTH) begin
          store[byte_count] = b;
          byte_count++;
        end
        if (byte_count >= STORE_DEPTH) in_frame = 1'b0;
      end
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        mismatches++;
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, got done=%0h cmd=%0h len=%0h st=%0h d=%0h",
                 $time, got.done, got.cmd, got.len, got.status, got.data);
        return;
      end
      want = expected_q.pop_front();
      compare_field("frame_done", want.done, got.done);
      compare_field("frame_command", want.cmd, got.cmd);
      compare_field("frame_length", want.len, got.len);
      compare_field("frame_status", want.status, got.status);
      compare_field("read_data", want.data, got.data);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [7:0]  in_rx_byte;
  logic [9:0]  in_read_index;
  logic        out_valid;
  logic        out_ready;
  logic        out_frame_done;
  logic [15:0] out_frame_command;
  logic [15:0] out_frame_length;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_read_data;
  logic        cfg_write_en;
  logic [9:0]  cfg_write_data;

  frame_checker_model model;
  int unsigned        items_sent;
  bit                 no_idle;

  sync_word_frame_checker_core #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_rx_byte        (in_rx_byte),
    .in_read_index     (in_read_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_frame_done    (out_frame_done),
    .out_frame_command (out_frame_command),
    .out_frame_length  (out_frame_length),
    .out_frame_status  (out_frame_status),
    .out_read_data     (out_read_data),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data)
  );

  always #5 clk = ~clk;

  // valid is only lowered when a gap follows, so back-to-back items keep it high
  task automatic send_item(logic op, logic [7:0] b, logic [9:0] idx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_rx_byte <= b;
    in_read_index <= idx;
    do @(posedge clk); while (in_ready !== 1'b1);
    model.take_item(op, b, idx);
    items_sent++;
  endtask

  task automatic send_push(logic [7:0] b);
    send_item(OP_PUSH, b, 10'($urandom_range(0, 1023)));
  endtask

  task automatic send_read(logic [9:0] idx);
    send_item(OP_READ, 8'($urandom_range(0, 255)), idx);
  endtask

  task automatic send_pattern(logic [63:0] pat);
    for (int k = 7; k >= 0; k--) send_push(pat[8*k +: 8]);
  endtask

  task automatic send_noise(int unsigned n);
    repeat (n) send_push(8'($urandom_range(0, 255)));
  endtask

  // start pattern, header, payload, checksum (less cut bytes), end pattern
  task automatic emit_frame(logic [15:0] cmd, logic [15:0] len_field,
                            int unsigned payload, bit bad_sum, int unsigned cut);
    logic [7:0]  body[$];
    logic [15:0] byte_sum;
    body = {};
    body.push_back(cmd[7:0]);
    body.push_back(cmd[15:8]);
    body.push_back(len_field[7:0]);
    body.push_back(len_field[15:8]);
    repeat (payload) body.push_back(8'($urandom_range(0, 255)));
    byte_sum = '0;
    foreach (body[i]) byte_sum += body[i];
    if (bad_sum) byte_sum ^= 16'(1) << $urandom_range(0, 15);
    body.push_back(byte_sum[7:0]);
    body.push_back(byte_sum[15:8]);
    repeat (cut) if (body.size() > 0) void'(body.pop_back());
    send_pattern(START_PATTERN);
    foreach (body[i]) send_push(body[i]);
    send_pattern(END_PATTERN);
  endtask

  function automatic logic [9:0] pick_read_index();
    int unsigned idx;
    case ($urandom_range(0, 3))
      0, 1: idx = (model.byte_count > 0) ? $urandom_range(0, model.byte_count - 1) : 0;
      2: idx = model.byte_count + $urandom_range(0, 3);
      default: idx = $urandom_range(0, 1023);
    endcase
    return (idx > 1023) ? 10'd1023 : 10'(idx);
  endfunction

  // pushes leave nothing in flight, so a short pause past the last result is enough
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (model.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_max_length(logic [9:0] v);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    model.max_length = v;
  endtask

  task automatic run_random(int unsigned quota);
    int unsigned stop_at, len;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      no_idle = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 99)) inside
        [0:49]: begin
          len = $urandom_range(0, 24);
          emit_frame(16'($urandom), 16'(len), len, $urandom_range(0, 3) == 0, 0);
        end
        [50:57]: begin
          // header never complete
          send_pattern(START_PATTERN);
          send_noise($urandom_range(0, 3));
          send_pattern(END_PATTERN);
        end
        [58:65]: begin
          len = $urandom_range(0, 20);
          emit_frame(16'($urandom), 16'(len), len, 1'b0, $urandom_range(1, len + 2));
        end
        [66:71]: begin
          emit_frame(16'($urandom), 16'($urandom_range(model.max_length + 1, 65535)),
                     $urandom_range(0, 8), 1'b0, 0);
        end
        [72:77]: begin
          // start pattern again inside an open frame
          send_pattern(START_PATTERN);
          send_noise($urandom_range(0, 10));
          len = $urandom_range(0, 16);
          emit_frame(16'($urandom), 16'(len), len, 1'b0, 0);
        end
        [78:83]: send_pattern(END_PATTERN);
        [84:89]: send_noise($urandom_range(1, 12));
        default: repeat ($urandom_range(1, 6)) send_read(pick_read_index());
      endcase
      if ($urandom_range(0, 9) < 3) repeat ($urandom_range(1, 3)) send_read(pick_read_index());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

  // result side: random stall before each item
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      model.check_result({out_frame_done, out_frame_command, out_frame_length,
                          out_frame_status, out_read_data});
    end
  end

  initial begin
    model = new();
    model.reset_state();
    items_sent = 0;
    no_idle = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_operation <= OP_PUSH;
    in_rx_byte <= '0;
    in_read_index <= '0;
    cfg_write_en <= 1'b0;
    cfg_write_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // minimal frame with zero-length payload, then reads in and past it
    emit_frame(16'hffff, 16'h0000, 0, 1'b0, 0);
    send_read(10'd0);
    send_read(10'd6);
    send_read(10'd1023);

    wait_idle();
    write_max_length(MAX_LENGTH_RESET);
    run_random(125);
    wait_idle();
    write_max_length(10'd0);
    run_random(125);
    wait_idle();
    write_max_length(10'($urandom_range(0, 1018)));
    run_random(125);
    wait_idle();
    write_max_length(10'd1018);
    run_random(125);

    wait_idle();
    repeat (50) @(posedge clk);
    if (model.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
